// ===== rtl/core/mandelbrot_escape_time_top_defines.svh =====
`ifndef MANDELBROT_ESCAPE_TIME_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MANDEL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define MANDEL_ASSERT_NEXT(label, cond, expct, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
        else $error(msg);

`endif

// ===== rtl/core/mandel_pkg.sv =====
package mandel_pkg;

    localparam int DATA_W            = 32;
    localparam int COUNT_W           = 16;
    localparam int FRACTION_BITS_DEF = 28;

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd256;

endpackage

// ===== rtl/core/mandel_mul.sv =====
module mandel_mul
    import mandel_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic signed [DATA_W-1:0] op_a,
    input  logic signed [DATA_W-1:0] op_b,
    output logic signed [DATA_W-1:0] prod
);

    logic signed [2*DATA_W-1:0] full_prod;
    logic signed [DATA_W-1:0]   prod_reg;

    assign full_prod = op_a * op_b;

    // keep the scaled product: arithmetic shift right, low word
    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod[FRACTION_BITS+DATA_W-1:FRACTION_BITS];
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/mandelbrot_escape_time_top.sv =====
// Escape-time unit for one point c = (c_real, c_imag), signed 32-bit with
// FRACTION_BITS fraction bits. Starting from z = c it iterates z = z*z + c on
// one shared 32x32 multiplier with a registered output: each iteration issues
// three products (zr*zr, zi*zi, zr*zi) and passes through CHECK, MII, MRI, UPD.
// A point keeps the block busy until its result is loaded into the output
// register once any earlier result is taken, then in_ready rises again;
// the result waits in an output register, so the next point is taken while it
// is still pending. The limit from cfg_data is sampled when a point is taken;
// cfg_ready is always high.
module mandelbrot_escape_time_top
    import mandel_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [COUNT_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [DATA_W-1:0]  c_real,
    input  logic signed [DATA_W-1:0]  c_imag,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COUNT_W-1:0]        iteration_count,
    output logic signed [DATA_W-1:0]  final_real,
    output logic signed [DATA_W-1:0]  final_imag,
    output logic                      escaped
);

    `include "mandelbrot_escape_time_top_defines.svh"

    localparam logic signed [DATA_W-1:0] BOX_LIM = DATA_W'(64'd2 << FRACTION_BITS);
    localparam logic signed [DATA_W-1:0] NEG_LIM = -BOX_LIM;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MII   = 6'b000100,
        ST_MRI   = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]       max_iter_reg;
    logic [COUNT_W-1:0]       limit_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [DATA_W-1:0] cr_reg, ci_reg, zr_reg, zi_reg, acc_reg;
    logic signed [DATA_W-1:0] op_a, op_b, prod;

    logic                     out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]       count_out_reg;
    logic signed [DATA_W-1:0] real_out_reg, imag_out_reg;
    logic                     esc_out_reg;

    logic in_fire, outside, more_iter, out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign more_iter = (count_reg < limit_reg);
    assign outside   = (zr_reg > BOX_LIM) || (zr_reg < NEG_LIM) ||
                       (zi_reg > BOX_LIM) || (zi_reg < NEG_LIM);

    assign op_a = (state_reg == ST_MII)   ? zi_reg : zr_reg;
    assign op_b = (state_reg == ST_CHECK) ? zr_reg : zi_reg;

    mandel_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!more_iter || outside)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MII;
                end
            end
            ST_MII: state_next = ST_MRI;
            ST_MRI: state_next = ST_UPD;
            ST_UPD: state_next = ST_CHECK;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            max_iter_reg  <= MAX_ITER_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_iter_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cr_reg    <= c_real;
            ci_reg    <= c_imag;
            zr_reg    <= c_real;
            zi_reg    <= c_imag;
            count_reg <= COUNT_W'(1);
            limit_reg <= max_iter_reg;
        end
        if (state_reg == ST_MII)
        begin
            acc_reg <= prod;
        end
        if (state_reg == ST_MRI)
        begin
            acc_reg <= acc_reg - prod;
        end
        if (state_reg == ST_UPD)
        begin
            zr_reg    <= acc_reg + cr_reg;
            zi_reg    <= (prod <<< 1) + ci_reg;
            count_reg <= count_reg + COUNT_W'(1);
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            count_out_reg <= count_reg;
            real_out_reg  <= zr_reg;
            imag_out_reg  <= zi_reg;
            esc_out_reg   <= more_iter;
        end
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = count_out_reg;
    assign final_real      = real_out_reg;
    assign final_imag      = imag_out_reg;
    assign escaped         = esc_out_reg;

    `MANDEL_ASSERT_NEXT(a_accept_to_check, in_fire, state_reg == ST_CHECK,
        "accepted transaction did not start the check")
    `MANDEL_ASSERT_NEXT(a_count_step, state_reg == ST_UPD,
        count_reg == $past(count_reg) + COUNT_W'(1), "count did not advance by one")
    `MANDEL_ASSERT(a_count_bound,
        (state_reg != ST_IDLE) && (state_reg != ST_CHECK || limit_reg != '0) &&
        (limit_reg != '0) |-> count_reg <= limit_reg, "count passed the limit")
    `MANDEL_ASSERT(a_result_source,
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE),
        "result loaded outside the done state")

endmodule

// ===== verif/mandelbrot_escape_time_top_test.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_time_top_test;
    import mandel_pkg::*;

    localparam int ONE              = 1 << FRACTION_BITS_DEF;
    localparam int BOX              = 2 << FRACTION_BITS_DEF;
    localparam int POINTS_PER_SWEEP = 160;
    localparam int DRAIN_HOLD       = 24;
    localparam int PRINT_LIMIT      = 40;
    localparam int WATCHDOG_LIMIT   = 1100000;

    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh80000000;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     escaped;
    } orbit_t;

    typedef struct {
        logic [COUNT_W-1:0]       limit;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        bit                       typed;
        orbit_t                   want;
    } probe_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [COUNT_W-1:0]       cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [DATA_W-1:0] c_real;
    logic signed [DATA_W-1:0] c_imag;
    logic                     out_valid;
    logic                     out_ready;
    logic [COUNT_W-1:0]       iteration_count;
    logic signed [DATA_W-1:0] final_real;
    logic signed [DATA_W-1:0] final_imag;
    logic                     escaped;

    orbit_t             orbit_ends[$];
    probe_t             probes[$];
    logic [COUNT_W-1:0] iter_limit;
    logic [COUNT_W-1:0] sweep_limits[10] = '{16'd256, 16'd3, 16'd1, 16'd40, 16'd2,
                                             16'd0, 16'd500, 16'd7, 16'd256, 16'd100};
    bit                 idle_on = 1'b1;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;

    mandelbrot_escape_time_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count),
        .final_real      (final_real),
        .final_imag      (final_imag),
        .escaped         (escaped)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic signed [DATA_W-1:0] fx_product(logic signed [DATA_W-1:0] a,
                                                            logic signed [DATA_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        p = p >>> FRACTION_BITS_DEF;
        return p[DATA_W-1:0];
    endfunction

    function automatic orbit_t trace_orbit(logic signed [DATA_W-1:0] c_re,
                                           logic signed [DATA_W-1:0] c_im,
                                           logic [COUNT_W-1:0] limit);
        orbit_t                   r;
        logic signed [DATA_W-1:0] zr;
        logic signed [DATA_W-1:0] zi;
        logic signed [DATA_W-1:0] nr;
        int unsigned              n;
        zr = c_re;
        zi = c_im;
        n  = 1;
        while (n < limit && !(zr > BOX || zr < -BOX || zi > BOX || zi < -BOX))
        begin
            nr = fx_product(zr, zr) - fx_product(zi, zi) + c_re;
            zi = (fx_product(zr, zi) <<< 1) + c_im;
            zr = nr;
            n++;
        end
        r.count   = n[COUNT_W-1:0];
        r.re      = zr;
        r.im      = zi;
        r.escaped = (n < limit);
        return r;
    endfunction

    function automatic void add_probe(logic [COUNT_W-1:0] limit, logic signed [DATA_W-1:0] re,
                                      logic signed [DATA_W-1:0] im, bit typed,
                                      logic [COUNT_W-1:0] cnt, logic signed [DATA_W-1:0] fr,
                                      logic signed [DATA_W-1:0] fi, logic esc);
        probe_t p;
        p.limit        = limit;
        p.re           = re;
        p.im           = im;
        p.typed        = typed;
        p.want.count   = cnt;
        p.want.re      = fr;
        p.want.im      = fi;
        p.want.escaped = esc;
        probes.push_back(p);
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Hold the sender until every pending result has come back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (orbit_ends.size() != 0);
    endtask

    task automatic set_limit(logic [COUNT_W-1:0] value);
        hold_until_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        iter_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic signed [DATA_W-1:0] re, logic signed [DATA_W-1:0] im,
                              bit typed, orbit_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        c_real   <= re;
        c_imag   <= im;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        orbit_ends.push_back(typed ? want : trace_orbit(re, im, iter_limit));
        @(negedge clk);
    endtask

    task automatic random_point(output logic signed [DATA_W-1:0] re,
                                output logic signed [DATA_W-1:0] im);
        logic signed [DATA_W-1:0] rim;
        case ($urandom_range(0, 5))
            0: rim = BOX;
            1: rim = BOX + 1;
            2: rim = -BOX;
            3: rim = -BOX - 1;
            4: rim = 0;
            default: rim = int'($urandom_range(0, 15)) - 8;
        endcase
        case ($urandom_range(0, 9))
            0, 1:
            begin
                re = $urandom;
                im = $urandom;
            end
            2, 3, 4, 5:
            begin
                re = int'($urandom_range(0, 2 * BOX)) - BOX;
                im = int'($urandom_range(0, 2 * BOX)) - BOX;
            end
            6, 7:
            begin
                re = int'($urandom_range(0, 5 * ONE / 4)) - 3 * ONE / 4;
                im = int'($urandom_range(0, ONE)) - ONE / 2;
            end
            default:
            begin
                re = rim;
                im = int'($urandom_range(0, 2 * BOX)) - BOX;
                if ($urandom_range(0, 1) == 1)
                begin
                    re = im;
                    im = rim;
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin : check_results
        orbit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (orbit_ends.size() == 0)
                report_mismatch("result with no point pending", DATA_W'(iteration_count),
                                '0);
            else
            begin
                want = orbit_ends.pop_front();
                if (iteration_count !== want.count)
                    report_mismatch("iteration_count", DATA_W'(iteration_count),
                                    DATA_W'(want.count));
                if (final_real !== want.re)
                    report_mismatch("final_real", final_real, want.re);
                if (final_imag !== want.im)
                    report_mismatch("final_imag", final_imag, want.im);
                if (escaped !== want.escaped)
                    report_mismatch("escaped", DATA_W'(escaped), DATA_W'(want.escaped));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 11) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : point_source
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        c_real     = '0;
        c_imag     = '0;
        iter_limit = MAX_ITER_RESET;

        add_probe(16'd256, 0, 0, 1'b1, 16'd256, 0, 0, 1'b0);
        add_probe(16'd256, MOST_POS, MOST_POS, 1'b1, 16'd1, MOST_POS, MOST_POS, 1'b1);
        add_probe(16'd256, MOST_NEG, MOST_NEG, 1'b1, 16'd1, MOST_NEG, MOST_NEG, 1'b1);
        add_probe(16'd256, MOST_POS, 0, 1'b1, 16'd1, MOST_POS, 0, 1'b1);
        add_probe(16'd256, 0, MOST_NEG, 1'b1, 16'd1, 0, MOST_NEG, 1'b1);
        add_probe(16'd256, BOX, 0, 1'b1, 16'd2, 3 * BOX, 0, 1'b1);
        add_probe(16'd256, -BOX, 0, 1'b1, 16'd256, BOX, 0, 1'b0);
        add_probe(16'd256, BOX, BOX, 1'b1, 16'd2, BOX, -3 * BOX, 1'b1);
        add_probe(16'd256, -BOX, -BOX, 1'b1, 16'd2, -BOX, 3 * BOX, 1'b1);
        add_probe(16'd256, BOX + 1, 0, 1'b1, 16'd1, BOX + 1, 0, 1'b1);
        add_probe(16'd256, 0, -BOX - 1, 1'b1, 16'd1, 0, -BOX - 1, 1'b1);
        add_probe(16'd256, 1, -1, 1'b0, '0, 0, 0, 1'b0);
        add_probe(16'd256, ONE / 4, ONE / 2, 1'b0, '0, 0, 0, 1'b0);
        add_probe(16'd256, -3 * ONE / 4, ONE / 10, 1'b0, '0, 0, 0, 1'b0);
        add_probe(16'd1, BOX, 0, 1'b1, 16'd1, BOX, 0, 1'b0);
        add_probe(16'd1, MOST_POS, MOST_NEG, 1'b1, 16'd1, MOST_POS, MOST_NEG, 1'b0);
        add_probe(16'd0, 0, 0, 1'b1, 16'd1, 0, 0, 1'b0);
        add_probe(16'd0, MOST_NEG, MOST_POS, 1'b1, 16'd1, MOST_NEG, MOST_POS, 1'b0);
        add_probe(16'd2, BOX, 0, 1'b1, 16'd2, 3 * BOX, 0, 1'b0);
        add_probe(16'd2, MOST_POS, 0, 1'b1, 16'd1, MOST_POS, 0, 1'b1);
        add_probe(16'd2, 0, ONE, 1'b0, '0, 0, 0, 1'b0);
        add_probe(16'd65535, 0, 0, 1'b1, 16'd65535, 0, 0, 1'b0);
        add_probe(16'd65535, MOST_NEG, 0, 1'b1, 16'd1, MOST_NEG, 0, 1'b1);
        add_probe(16'd65535, BOX, BOX, 1'b1, 16'd2, BOX, -3 * BOX, 1'b1);
        add_probe(16'd3, ONE, ONE, 1'b0, '0, 0, 0, 1'b0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (probes[i])
        begin
            if (probes[i].limit != iter_limit)
                set_limit(probes[i].limit);
            send_point(probes[i].re, probes[i].im, probes[i].typed, probes[i].want);
        end

        sweep_limits[9] = COUNT_W'($urandom_range(1, 300));
        foreach (sweep_limits[p])
        begin
            set_limit(sweep_limits[p]);
            for (int n = 0; n < POINTS_PER_SWEEP; n++)
            begin
                if (n % 40 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 63) == 0)
                    hold_until_drained();
                random_point(re, im);
                send_point(re, im, 1'b0, '0);
            end
        end

        hold_until_drained();
        repeat (DRAIN_HOLD) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== mandelbrot_escape_time_top.f =====
+incdir+rtl/core
rtl/core/mandel_pkg.sv
rtl/core/mandel_mul.sv
rtl/core/mandelbrot_escape_time_top.sv
verif/mandelbrot_escape_time_top_test.sv
